@@ sv/b85e_pkg.sv @@
// ----------------------------------------------------------------------------
// b85e_pkg
// shared types, character codes and lookup functions for the base85 encoder
// ----------------------------------------------------------------------------
package b85e_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE85_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELIM_EN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DELIM_CHAR  = 2'd2;

    localparam logic [7:0] RST_DELIM_CHAR = 8'd44;

    localparam logic [7:0] CH_HEADER = 8'h47;   // 'G'
    localparam logic [7:0] CH_ZEROS  = 8'h5B;   // '['
    localparam logic [7:0] CH_ONES   = 8'h5C;   // backslash
    localparam logic [7:0] CH_SPACES = 8'h5D;   // ']'

    localparam logic [31:0] WORD_ONES   = 32'hFFFF_FFFF;
    localparam logic [31:0] WORD_SPACES = 32'h2020_2020;

    // ceil(2^38 / 85), exact quotient for any 32-bit word
    localparam logic [31:0] RECIP85     = 32'hC0C0_C0C1;
    localparam int          RECIP_SHIFT = 38;

    typedef enum logic [1:0] {
        BODY_NONE,
        BODY_CHAR,
        BODY_DIG5,
        BODY_HEX2
    } t_body;

    typedef struct packed {
        logic        delim;
        logic        hdr;
        t_body       body;
        logic [7:0]  delim_char;
        logic [31:0] word;
    } t_job;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = {4'b0, nib} + 8'h30;
        end else begin
            c = {4'b0, nib} + 8'h37;
        end
        return c;
    endfunction

    function automatic logic [7:0] dig85_char(input logic [6:0] r);
        logic [7:0] c;
        if (r < 7'd10) begin
            c = {1'b0, r} + 8'h30;
        end else if (r < 7'd36) begin
            c = {1'b0, r} + 8'h37;
        end else if (r < 7'd62) begin
            c = {1'b0, r} + 8'h3D;
        end else begin
            case (r)
                7'd62:   c = 8'h21;
                7'd63:   c = 8'h23;
                7'd64:   c = 8'h24;
                7'd65:   c = 8'h25;
                7'd66:   c = 8'h26;
                7'd67:   c = 8'h28;
                7'd68:   c = 8'h29;
                7'd69:   c = 8'h2B;
                7'd70:   c = 8'h2D;
                7'd71:   c = 8'h2F;
                7'd72:   c = 8'h3B;
                7'd73:   c = 8'h3C;
                7'd74:   c = 8'h3D;
                7'd75:   c = 8'h3E;
                7'd76:   c = 8'h3F;
                7'd77:   c = 8'h40;
                7'd78:   c = 8'h5E;
                7'd79:   c = 8'h5F;
                7'd80:   c = 8'h60;
                7'd81:   c = 8'h7B;
                7'd82:   c = 8'h7C;
                7'd83:   c = 8'h7D;
                default: c = 8'h7E;
            endcase
        end
        return c;
    endfunction

endpackage

@@ sv/base85_block_encoder_unit.sv @@
// ----------------------------------------------------------------------------
// base85_block_encoder_unit
// byte stream to base85 or hex text encoder with run shortcuts
// ----------------------------------------------------------------------------
// Accepts one byte per word and emits one ASCII character per cycle while
// the sink is ready. A byte that only fills a base85 group and starts no
// block gives nothing; one that gives n characters (one to five) keeps the
// emitter busy, one base85 digit per ready cycle from a single divide-by-85
// step. A one-job holding register lets the next byte be taken while the
// current job is being emitted, so output runs at one character per cycle
// with jobs waiting and a ready sink. tlast marks each byte's last character.
module base85_block_encoder_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [7:0]                        i_s_tdata,   // data_byte
    input  logic                              i_s_tuser,   // first_of_block
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [7:0]                        o_m_tdata,   // out_char
    output logic                              o_m_tlast,   // run_last
    input  logic                              i_cfg_we,
    input  logic [b85e_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [b85e_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import b85e_pkg::*;

    logic        r_base85_mode;
    logic        r_delim_en;
    logic [7:0]  r_delim_char;
    logic [23:0] r_held;
    logic [1:0]  r_fill;
    logic        r_pend_valid;
    t_job        r_pend;

    logic        accept;
    logic        take;
    logic [23:0] held_eff;
    logic [1:0]  fill_eff;
    logic [31:0] word;
    logic [23:0] n_held;
    logic [1:0]  n_fill;
    t_job        job;
    logic        job_valid;

    assign o_s_tready = !r_pend_valid || take;
    assign accept     = i_s_tvalid && o_s_tready;

    assign held_eff = i_s_tuser ? 24'd0 : r_held;
    assign fill_eff = i_s_tuser ? 2'd0 : r_fill;
    assign word     = {i_s_tdata, held_eff};

    always_comb begin
        n_held         = held_eff;
        n_fill         = fill_eff;
        job.delim      = i_s_tuser && r_delim_en;
        job.hdr        = 1'b0;
        job.body       = BODY_NONE;
        job.delim_char = r_delim_char;
        job.word       = {24'd0, i_s_tdata};
        if (r_base85_mode) begin
            job.hdr = i_s_tuser;
            case (fill_eff)
                2'd0:    n_held = {16'd0, i_s_tdata};
                2'd1:    n_held = {8'd0, i_s_tdata, held_eff[7:0]};
                2'd2:    n_held = {i_s_tdata, held_eff[15:0]};
                default: n_held = 24'd0;
            endcase
            if (fill_eff == 2'd3) begin
                n_fill = 2'd0;
                if (word == 32'd0) begin
                    job.body = BODY_CHAR;
                    job.word = {24'd0, CH_ZEROS};
                end else if (word == WORD_ONES) begin
                    job.body = BODY_CHAR;
                    job.word = {24'd0, CH_ONES};
                end else if (word == WORD_SPACES) begin
                    job.body = BODY_CHAR;
                    job.word = {24'd0, CH_SPACES};
                end else begin
                    job.body = BODY_DIG5;
                    job.word = word;
                end
            end else begin
                n_fill = fill_eff + 2'd1;
            end
        end else begin
            job.body = BODY_HEX2;
        end
    end

    assign job_valid = job.delim || job.hdr || (job.body != BODY_NONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base85_mode <= 1'b1;
            r_delim_en    <= 1'b1;
            r_delim_char  <= RST_DELIM_CHAR;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BASE85_MODE: r_base85_mode <= i_cfg_data[0];
                CFG_DELIM_EN:    r_delim_en    <= i_cfg_data[0];
                CFG_DELIM_CHAR:  r_delim_char  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held       <= 24'd0;
            r_fill       <= 2'd0;
            r_pend_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_held <= n_held;
                r_fill <= n_fill;
            end
            if (accept && job_valid) begin
                r_pend_valid <= 1'b1;
            end else if (take) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && job_valid) begin
            r_pend <= job;
        end
    end

    b85e_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (r_pend_valid),
        .i_job       (r_pend),
        .o_take      (take),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

endmodule

@@ sv/b85e_emit.sv @@
// ----------------------------------------------------------------------------
// b85e_emit
// character emitter: walks one job, one character per cycle while the sink is ready, into the
// output register; base85 digits come from a divide-by-85 step per cycle
// ----------------------------------------------------------------------------
module b85e_emit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_valid,
    input  b85e_pkg::t_job i_job,
    output logic           o_take,
    output logic           o_m_tvalid,
    input  logic           i_m_tready,
    output logic [7:0]     o_m_tdata,   // out_char
    output logic           o_m_tlast    // run_last
);
    import b85e_pkg::*;

    logic        r_act;
    t_job        r_job;
    logic [2:0]  r_dcnt;
    logic        r_out_valid;
    logic [7:0]  r_out_char;
    logic        r_out_last;

    logic        advance;
    logic [7:0]  cur_char;
    logic        cur_last;
    logic [63:0] prod;
    logic [25:0] quo;
    logic [31:0] quo85;
    logic [31:0] rem32;

    assign prod  = {32'b0, r_job.word} * {32'b0, RECIP85};
    assign quo   = prod[63:RECIP_SHIFT];
    assign quo85 = {quo, 6'b0} + {2'b0, quo, 4'b0} + {4'b0, quo, 2'b0} + {6'b0, quo};
    assign rem32 = r_job.word - quo85;

    assign advance = !r_out_valid || i_m_tready;
    assign o_take  = i_job_valid && (!r_act || (advance && cur_last));

    always_comb begin
        cur_char = 8'h00;
        cur_last = 1'b1;
        if (r_job.delim) begin
            cur_char = r_job.delim_char;
            cur_last = !r_job.hdr && (r_job.body == BODY_NONE);
        end else if (r_job.hdr) begin
            cur_char = CH_HEADER;
            cur_last = (r_job.body == BODY_NONE);
        end else begin
            case (r_job.body)
                BODY_CHAR: begin
                    cur_char = r_job.word[7:0];
                    cur_last = 1'b1;
                end
                BODY_HEX2: begin
                    cur_char = r_dcnt[0] ? hex_char(r_job.word[3:0])
                                         : hex_char(r_job.word[7:4]);
                    cur_last = r_dcnt[0];
                end
                BODY_DIG5: begin
                    cur_char = dig85_char(rem32[6:0]);
                    cur_last = (r_dcnt == 3'd4);
                end
                default: begin
                    cur_char = 8'h00;
                    cur_last = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act       <= 1'b0;
            r_dcnt      <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= r_act;
            end
            if (o_take) begin
                r_act  <= 1'b1;
                r_job  <= i_job;
                r_dcnt <= 3'd0;
            end else if (advance && r_act) begin
                if (cur_last) begin
                    r_act <= 1'b0;
                end else if (r_job.delim) begin
                    r_job.delim <= 1'b0;
                end else if (r_job.hdr) begin
                    r_job.hdr <= 1'b0;
                end else begin
                    if (r_job.body == BODY_DIG5) begin
                        r_job.word <= {6'b0, quo};
                    end
                    r_dcnt <= r_dcnt + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_act) begin
            r_out_char <= cur_char;
            r_out_last <= cur_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_char;
    assign o_m_tlast  = r_out_last;

endmodule

@@ test/base85_block_encoder_unit_tb.sv @@
// ----------------------------------------------------------------------------
// base85_block_encoder_unit_tb
// self-checking bench for the base85 / hex block encoder
// ----------------------------------------------------------------------------
// Bytes go in on the slave stream and characters come out on the master
// stream. A scoreboard class keeps its own copy of the encoder registers and
// of the partial base85 group. For each accepted byte it queues the
// characters that byte should give, and it checks every output word against
// the oldest one in the queue. A short directed sequence comes first. It
// covers the shortcut words, a full five-digit word, a dropped trailing
// group, hex mode and a mode switch in the middle of a block. Random blocks
// follow under eight register settings and four idle/stall patterns.
// ----------------------------------------------------------------------------
module base85_block_encoder_unit_tb;
    import b85e_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 10;

    // base85 digits 62..84, lowest digit in the low byte
    localparam logic [23*8-1:0] PUNCT85 = {
        8'h7E, 8'h7D, 8'h7C, 8'h7B, 8'h60, 8'h5F, 8'h5E, 8'h40,
        8'h3F, 8'h3E, 8'h3D, 8'h3C, 8'h3B, 8'h2F, 8'h2D, 8'h2B,
        8'h29, 8'h28, 8'h26, 8'h25, 8'h24, 8'h23, 8'h21
    };

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_text_char;

    class b85_scoreboard;
        logic            base85_on;
        logic            delim_on;
        logic [7:0]      delim_code;
        logic [23:0]     held;
        logic [1:0]      fill;
        t_text_char      text_q[$];
        int              errors;
        int              chars_checked;
        string           hexset;

        function new();
            base85_on     = 1'b1;
            delim_on      = 1'b1;
            delim_code    = RST_DELIM_CHAR;
            held          = '0;
            fill          = '0;
            errors        = 0;
            chars_checked = 0;
            hexset        = "0123456789ABCDEF";
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
            case (idx)
                CFG_BASE85_MODE: base85_on  = val[0];
                CFG_DELIM_EN:    delim_on   = val[0];
                CFG_DELIM_CHAR:  delim_code = val;
                default: ;
            endcase
        endfunction

        function logic [7:0] digit_char(int unsigned d);
            if (d < 10) return 8'h30 + d[7:0];
            if (d < 36) return 8'h41 + d[7:0] - 8'd10;
            if (d < 62) return 8'h61 + d[7:0] - 8'd36;
            return PUNCT85[8*(d-62) +: 8];
        endfunction

        function void note_byte(logic [7:0] b, logic f);
            logic [7:0]  text[$];
            logic [31:0] w;
            int unsigned v;
            t_text_char  e;
            if (f) begin
                held = '0;
                fill = '0;
            end
            if (base85_on) begin
                if (f) begin
                    if (delim_on) text.push_back(delim_code);
                    text.push_back(CH_HEADER);
                end
                if (fill < 2'd3) begin
                    held[8*fill +: 8] = b;
                    fill = fill + 2'd1;
                end else begin
                    w    = {b, held};
                    held = '0;
                    fill = '0;
                    if (w == 32'd0) begin
                        text.push_back(CH_ZEROS);
                    end else if (w == WORD_ONES) begin
                        text.push_back(CH_ONES);
                    end else if (w == WORD_SPACES) begin
                        text.push_back(CH_SPACES);
                    end else begin
                        v = w;
                        for (int k = 0; k < 5; k++) begin
                            text.push_back(digit_char(v % 85));
                            v = v / 85;
                        end
                    end
                end
            end else begin
                if (f && delim_on) text.push_back(delim_code);
                text.push_back(hexset[b[7:4]]);
                text.push_back(hexset[b[3:0]]);
            end
            foreach (text[k]) begin
                e.ch   = text[k];
                e.last = (k == text.size() - 1);
                text_q.push_back(e);
            end
        endfunction

        function void check_char(logic [7:0] c, logic l);
            t_text_char e;
            chars_checked++;
            if (text_q.size() == 0) begin
                $error("unexpected word: out_char %h run_last %b", c, l);
                errors++;
                return;
            end
            e = text_q.pop_front();
            if (c !== e.ch) begin
                $error("out_char mismatch: expected %h, got %h", e.ch, c);
                errors++;
            end
            if (l !== e.last) begin
                $error("run_last mismatch: expected %b, got %b", e.last, l);
                errors++;
            end
        endfunction

        function int pending();
            return text_q.size();
        endfunction
    endclass

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [7:0]            i_s_tdata  = '0;   // data_byte
    logic                  i_s_tuser  = 1'b0; // first_of_block
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [7:0]            o_m_tdata;         // out_char
    logic                  o_m_tlast;         // run_last
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    b85_scoreboard sb = new();
    int src_idle_pct  = 0;
    int sink_stall_pct = 0;
    int bytes_sent    = 0;
    int settings_used = 1;
    int cycles        = 0;

    base85_block_encoder_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("base85_block_encoder_unit_tb: errors");
            $finish;
        end
    end

    // character sink with random back-pressure
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_char(o_m_tdata, o_m_tlast);
            i_m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic f);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tuser  <= f;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_byte(b, f);
        bytes_sent++;
    endtask

    // stop sending, let all characters out, then let the pipeline settle
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_regs(input logic mode, input logic den, input logic [7:0] dch);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_BASE85_MODE;
        i_cfg_data <= {7'd0, mode};
        @(posedge i_clk);
        sb.set_reg(CFG_BASE85_MODE, {7'd0, mode});
        i_cfg_idx  <= CFG_DELIM_EN;
        i_cfg_data <= {7'd0, den};
        @(posedge i_clk);
        sb.set_reg(CFG_DELIM_EN, {7'd0, den});
        i_cfg_idx  <= CFG_DELIM_CHAR;
        i_cfg_data <= dch;
        @(posedge i_clk);
        sb.set_reg(CFG_DELIM_CHAR, dch);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic push_word(input logic [31:0] w, input logic f);
        push_byte(w[7:0], f);
        push_byte(w[15:8], 1'b0);
        push_byte(w[23:16], 1'b0);
        push_byte(w[31:24], 1'b0);
    endtask

    function automatic logic [31:0] pick_word();
        logic [31:0] w;
        int          r;
        r = $urandom_range(99);
        if (r < 15) w = 32'd0;
        else if (r < 30) w = WORD_ONES;
        else if (r < 40) w = WORD_SPACES;
        else w = $urandom;
        // near misses of the shortcut words
        if (r >= 40 && r < 55) begin
            w = (r < 45) ? 32'd0 : (r < 50) ? WORD_ONES : WORD_SPACES;
            w[8*$urandom_range(3) +: 8] = 8'($urandom_range(255));
        end
        return w;
    endfunction

    task automatic send_block();
        int n_words;
        int n_trail;
        n_words = $urandom_range(1, 4);
        for (int k = 0; k < n_words; k++) push_word(pick_word(), k == 0);
        if ($urandom_range(3) == 0) begin
            n_trail = $urandom_range(1, 3);
            for (int k = 0; k < n_trail; k++) push_byte(8'($urandom_range(255)), 1'b0);
        end
    endtask

    initial begin
        logic       mode;
        logic       den;
        logic [7:0] dch;
        int         target;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // bytes with no block start, then the shortcut words and a full word
        push_word(32'h0403_0201, 1'b0);
        push_word(32'h0000_0000, 1'b1);
        push_word(WORD_ONES, 1'b0);
        push_word(WORD_SPACES, 1'b0);
        push_word(32'hFFFF_FFFE, 1'b0);
        // trailing partial group dropped by a new block
        push_byte(8'hAA, 1'b0);
        push_byte(8'h55, 1'b0);
        push_byte(8'h7F, 1'b1);
        push_byte(8'h80, 1'b0);
        wait_drained();
        // hex bytes in the middle of a partial base85 group
        write_regs(1'b0, 1'b1, RST_DELIM_CHAR);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h0F, 1'b0);
        wait_drained();
        write_regs(1'b1, 1'b1, RST_DELIM_CHAR);
        push_byte(8'h12, 1'b0);
        push_byte(8'h34, 1'b0);
        wait_drained();
        // hex block starts with and without delimiter
        write_regs(1'b0, 1'b1, 8'h00);
        push_byte(8'hA5, 1'b1);
        push_byte(8'h00, 1'b0);
        wait_drained();
        write_regs(1'b0, 1'b0, 8'hFF);
        push_byte(8'h3C, 1'b1);
        wait_drained();
        write_regs(1'b1, 1'b0, 8'hFF);
        push_byte(8'h00, 1'b1);
        wait_drained();

        for (int s = 0; s < 8; s++) begin
            case (s / 2)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 83; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 83; end
                default: begin src_idle_pct = 11; sink_stall_pct = 11; end
            endcase
            mode = (s % 2 == 0);
            den  = !(s == 2 || s == 3 || s == 7);
            dch  = (s % 4 == 0) ? 8'hFF : (s % 4 == 2) ? 8'h00 : 8'($urandom_range(255));
            write_regs(mode, den, dch);
            target = bytes_sent + 6;
            while (bytes_sent < target) begin
                if ($urandom_range(99) < 15) begin
                    push_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
                end else begin
                    send_block();
                end
            end
            wait_drained();
        end

        $display("%0d bytes in, %0d characters checked", bytes_sent, sb.chars_checked);
        $display("%0d register settings, four idle and stall patterns", settings_used);
        if (sb.errors == 0) begin
            $display("base85_block_encoder_unit_tb: clean");
        end else begin
            $display("base85_block_encoder_unit_tb: errors");
        end
        $finish;
    end

endmodule
